// ===== rtl/hrt_pkg.sv =====
// hodoscope road trigger package: widths, register indexes, request codes
// and the delay helper; no dependencies
package hrt_pkg;
  localparam int FrontBars = 32;
  localparam int BackBars  = 64;
  localparam int H4Bars    = 16;
  localparam int FW = $clog2(FrontBars);
  localparam int BW = $clog2(BackBars);
  localparam int AW = FW + BW;
  localparam int NSets = 12;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_HIT  = 2'd1;
  localparam logic [1:0] REQ_EOE  = 2'd2;

  localparam logic [2:0] REG_WINDOW = 3'd0;
  localparam logic [2:0] REG_NIM1_MASK = 3'd1;
  localparam logic [2:0] REG_NIM1_SHIFT = 3'd2;
  localparam logic [2:0] REG_NIM3_MASK = 3'd3;
  localparam logic [2:0] REG_NIM3_SHIFT = 3'd4;

  typedef struct packed {
    logic [9:0] window_half;
    logic [7:0] nim1_mask;
    logic [9:0] nim1_shift;
    logic [7:0] nim3_mask;
    logic [9:0] nim3_shift;
  } cfg_t;

  function automatic logic [14:0] set_delay(input logic [3:0] s, input logic [5:0] bar);
    case (s)
      4'd0: set_delay = 15'd17280;
      4'd1: set_delay = 15'd17200;
      4'd2: set_delay = 15'd17300;
      4'd3: set_delay = (bar > 6'd15) ? 15'd17160 : 15'd17210;
      4'd4: set_delay = (bar > 6'd32) ? 15'd16950 : 15'd17030;
      4'd5: set_delay = 15'd16970;
      4'd6: set_delay = 15'd17040;
      4'd7: set_delay = (bar > 6'd32) ? 15'd16950 : 15'd16890;
      4'd8: set_delay = 15'd10920;
      4'd9: set_delay = 15'd10910;
      4'd10: set_delay = 15'd10930;
      default: set_delay = 15'd10920;
    endcase
  endfunction
endpackage

// ===== rtl/hrt_if.sv =====
// valid/ready channel interfaces for the hodoscope road trigger
// depends on nothing
interface hrt_in_if;
  logic valid, ready;
  logic [1:0] req_type;
  logic [4:0] road_front;
  logic [5:0] road_back;
  logic [3:0] road_h4;
  logic [7:0] detector_num;
  logic [5:0] element_num;
  logic [14:0] hit_time;
  logic [7:0] trigger_word;
  modport source(output valid, req_type, road_front, road_back, road_h4, detector_num,
    element_num, hit_time, trigger_word, input ready);
  modport sink(input valid, req_type, road_front, road_back, road_h4, detector_num,
    element_num, hit_time, trigger_word, output ready);
endinterface

interface hrt_out_if;
  logic valid, ready;
  logic [3:0] road_bits, road_bits_untimed, back_bits;
  logic [7:0] event_trigger;
  modport source(output valid, road_bits, road_bits_untimed, back_bits, event_trigger,
    input ready);
  modport sink(input valid, road_bits, road_bits_untimed, back_bits, event_trigger,
    output ready);
endinterface

interface hrt_cfg_if;
  logic valid, ready;
  logic [2:0] index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/hrt_road_ram.sv =====
// road table memory, one write and one registered read port
// depends on hrt_pkg
module hrt_road_ram
  import hrt_pkg::*;
(
  input  logic clk,
  input  logic we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [15:0] rdata
);
  logic [15:0] mem [FrontBars*BackBars];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/hodoscope_road_trigger_core.sv =====
// hodoscope road trigger top: config registers, masks, road table walk
// depends on hrt_pkg, hrt_if, hrt_road_ram
//
// channel | dir | beat
// in      | in  | load / hit / end of event request
// out     | out | per quadrant road, untimed road and back flags, event trigger word
// cfg     | in  | register index and data
//
// load: read-modify-write through S_LRD and S_LWR; after reset a 2048-row clear sweep comes first
// hit: in S_IDLE; end of event (trigger != 0): 2048-row scan in S_SCAN, then S_OUT, one read per cycle
// the road memory read port sets the end of event time; rst_n synchronously clears
// control, then a 2048-row clear sweep runs, no item taken meanwhile
// a waiting result stalls only the next end of event, at the end of its scan
module hodoscope_road_trigger_core
  import hrt_pkg::*;
(
  input logic clk,
  input logic rst_n,
  hrt_in_if.sink in_ch,
  hrt_out_if.source out_ch,
  hrt_cfg_if.sink cfg_ch
);
  localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_LRD = 3'd2, S_LWR = 3'd3,
    S_SCAN = 3'd4, S_OUT = 3'd5;
  logic [2:0] st_r;
  cfg_t cfg_r;
  logic [63:0] tm_r [NSets];
  logic [63:0] um_r [NSets];
  logic [AW:0] cnt_r;
  logic [AW-1:0] la_r;
  logic [3:0] lh_r;
  logic [3:0] rb_r, ru_r;
  logic [7:0] trig_r;
  logic pv_r;
  logic [AW-1:0] pa_r;
  logic ovalid_r;
  logic [3:0] obr_r, obu_r, obb_r;
  logic [7:0] otr_r;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [15:0] wdata, rdata;
  hrt_road_ram u_ram(.clk, .we, .waddr, .wdata, .raddr, .rdata);

  logic acc;
  assign in_ch.ready = (st_r == S_IDLE);
  assign acc = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // hit mapping
  logic hv;
  logic [3:0] hset;
  logic [5:0] hbar;
  logic signed [17:0] d;
  logic [9:0] sh;
  always_comb begin
    hv = 1'b1; hset = 4'd0; hbar = in_ch.element_num;
    if (in_ch.detector_num >= 8'd55 && in_ch.detector_num <= 8'd62)
      hset = 4'(in_ch.detector_num - 8'd55);
    else if (in_ch.detector_num == 8'd43 || in_ch.detector_num == 8'd44) begin
      if (in_ch.element_num > 6'd8) begin
        hset = 4'd8 + {3'd0, in_ch.detector_num[0] ^ 1'b1};
        hbar = in_ch.element_num - 6'd8;
      end else begin
        hset = 4'd10 + {3'd0, in_ch.detector_num[0] ^ 1'b1};
        hbar = 6'd9 - in_ch.element_num;
      end
    end else hv = 1'b0;
    if (in_ch.trigger_word == cfg_r.nim1_mask) sh = cfg_r.nim1_shift;
    else if (in_ch.trigger_word == cfg_r.nim3_mask) sh = cfg_r.nim3_shift;
    else sh = '0;
    d = $signed({3'd0, in_ch.hit_time}) - $signed({3'd0, set_delay(hset, hbar)})
      - $signed({8'd0, sh});
  end
  logic intime;
  assign intime = (d < $signed({8'd0, cfg_r.window_half}))
    && (-d < $signed({8'd0, cfg_r.window_half}));

  // scan address decode: cnt = front*BackBars + back
  logic [FW-1:0] sf;
  logic [BW-1:0] sb;
  assign sf = cnt_r[AW-1:BW];
  assign sb = cnt_r[BW-1:0];
  logic [FW-1:0] pf;
  logic [BW-1:0] pb;
  assign pf = pa_r[AW-1:BW];
  assign pb = pa_r[BW-1:0];

  logic [3:0] mt, mu;
  always_comb begin
    for (int q = 0; q < 4; q++) begin
      mt[q] = tm_r[q][pf] && tm_r[q+4][pb] && |(rdata & tm_r[q+8][H4Bars-1:0]);
      mu[q] = um_r[q][pf] && um_r[q+4][pb] && |(rdata & um_r[q+8][H4Bars-1:0]);
    end
  end

  always_comb begin
    we = 1'b0; waddr = la_r; wdata = rdata | (16'd1 << lh_r);
    raddr = la_r;
    if (st_r == S_CLR) begin
      we = 1'b1; waddr = cnt_r[AW-1:0]; wdata = '0;
    end else if (st_r == S_LWR) we = 1'b1;
    if (st_r == S_SCAN) raddr = cnt_r[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; cnt_r <= '0; ovalid_r <= 1'b0; pv_r <= 1'b0;
      cfg_r <= '{10'd94, 8'd32, 10'd50, 8'd128, 10'd150};
      for (int i = 0; i < NSets; i++) begin
        tm_r[i] <= '0; um_r[i] <= '0;
      end
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          REG_WINDOW: cfg_r.window_half <= cfg_ch.data[9:0];
          REG_NIM1_MASK: cfg_r.nim1_mask <= cfg_ch.data[7:0];
          REG_NIM1_SHIFT: cfg_r.nim1_shift <= cfg_ch.data[9:0];
          REG_NIM3_MASK: cfg_r.nim3_mask <= cfg_ch.data[7:0];
          REG_NIM3_SHIFT: cfg_r.nim3_shift <= cfg_ch.data[9:0];
          default: ;
        endcase
      end
      if (ovalid_r && out_ch.ready) ovalid_r <= 1'b0;
      case (st_r)
        S_CLR: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == (AW+1)'(FrontBars*BackBars-1)) st_r <= S_IDLE;
        end
        S_IDLE: if (acc) begin
          case (in_ch.req_type)
            REQ_LOAD: begin
              la_r <= {in_ch.road_front[FW-1:0], in_ch.road_back[BW-1:0]};
              lh_r <= in_ch.road_h4;
              st_r <= S_LRD;
            end
            REQ_HIT: if (hv && in_ch.trigger_word != 8'd0) begin
              um_r[hset][hbar] <= 1'b1;
              if (intime) tm_r[hset][hbar] <= 1'b1;
            end
            REQ_EOE: begin
              if (in_ch.trigger_word == 8'd0) begin
                for (int i = 0; i < NSets; i++) begin
                  tm_r[i] <= '0; um_r[i] <= '0;
                end
              end else begin
                trig_r <= in_ch.trigger_word; rb_r <= '0; ru_r <= '0;
                cnt_r <= '0; pv_r <= 1'b0; st_r <= S_SCAN;
              end
            end
            default: ;
          endcase
        end
        S_LRD: st_r <= S_LWR;
        S_LWR: st_r <= S_IDLE;
        S_SCAN: begin
          pv_r <= !cnt_r[AW]; pa_r <= cnt_r[AW-1:0];
          if (pv_r) begin
            rb_r <= rb_r | mt; ru_r <= ru_r | mu;
          end
          if (!cnt_r[AW]) cnt_r <= cnt_r + 1'b1;
          else st_r <= S_OUT;
        end
        S_OUT: if (!ovalid_r) begin
          ovalid_r <= 1'b1; otr_r <= trig_r;
          obr_r <= rb_r; obu_r <= ru_r;
          for (int q = 0; q < 4; q++) obb_r[q] <= |tm_r[q+4];
          for (int i = 0; i < NSets; i++) begin
            tm_r[i] <= '0; um_r[i] <= '0;
          end
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.road_bits = obr_r;
  assign out_ch.road_bits_untimed = obu_r;
  assign out_ch.back_bits = obb_r;
  assign out_ch.event_trigger = otr_r;
endmodule
